FILE: rtl/rpr_pkg.sv
// Package for the random page replacement block.
// Holds the word types of both channels, the scan response type and fixed constants.
// No dependencies.
package rpr_pkg;

  // Fixed field widths
  localparam int PAGE_W   = 7;
  localparam int RAND_W   = 16;
  localparam int FRAME_W  = 8;
  localparam int HITS_W   = 32;
  localparam int COUNT_W  = 8;

  // Frame count after reset
  localparam logic [FRAME_W-1:0] FRAME_RESET = 8'd128;

  // Input word
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [RAND_W-1:0] random_value;
    logic              last_of_run;
  } rpr_in_t;

  // Result word
  typedef struct packed {
    logic               hit;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [HITS_W-1:0]  hit_total;
    logic [COUNT_W-1:0] resident_count;
    logic               run_end;
  } rpr_out_t;

  // Victim scan response
  typedef struct packed {
    logic              done;
    logic [PAGE_W-1:0] victim;
  } rpr_scan_rsp_t;

endpackage

FILE: rtl/rpr_scan.sv
// Victim scan unit: walks the present map eight pages per cycle and finds
// the k-th present page in ascending order. Depends on rpr_pkg.
module rpr_scan #(
  parameter int PAGE_COUNT = 128,
  parameter int RES_W      = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [RES_W-1:0]        k,
  input  logic [PAGE_COUNT-1:0]   map,
  output rpr_pkg::rpr_scan_rsp_t  rsp
);

  localparam int NCHUNK = (PAGE_COUNT + 7) / 8;
  localparam int CI_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W  = (1 << CI_W) * 8;
  localparam int FI_W   = CI_W + 3;
  localparam int SUM_W  = RES_W + 4;

  logic              active_r, active_nxt;
  logic [CI_W-1:0]   idx_r, idx_nxt;
  logic [RES_W-1:0]  seen_r, seen_nxt;
  logic [RES_W-1:0]  k_r, k_nxt;
  logic              done_r, done_nxt;
  logic [rpr_pkg::PAGE_W-1:0] victim_r, victim_nxt;

  logic [PAD_W-1:0]  map_pad;
  logic [7:0]        chunk;
  logic [SUM_W-1:0]  pop;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  cnt;
  logic [2:0]        pos;
  logic              found;
  logic [FI_W-1:0]   full_idx;
  logic [FI_W+rpr_pkg::PAGE_W-1:0] full_ext;

  // Select the current group of eight pages
  assign map_pad = PAD_W'(map);
  assign chunk   = map_pad[{idx_r, 3'b000} +: 8];
  assign rem     = SUM_W'(k_r) - SUM_W'(seen_r);

  // Count present pages in the group and locate the wanted one
  always_comb begin
    pop   = '0;
    cnt   = '0;
    pos   = '0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (chunk[i]) begin
        if (!found && cnt == rem) begin
          pos   = 3'(i);
          found = 1'b1;
        end
        cnt = cnt + 1'b1;
        pop = pop + 1'b1;
      end
    end
  end

  assign full_idx = {idx_r, pos};
  assign full_ext = {{rpr_pkg::PAGE_W{1'b0}}, full_idx};

  // Advance one group per cycle, stop on the victim
  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    seen_nxt   = seen_r;
    k_nxt      = k_r;
    done_nxt   = 1'b0;
    victim_nxt = victim_r;
    if (start) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
      seen_nxt   = '0;
      k_nxt      = k;
    end else if (active_r) begin
      if (found) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
        victim_nxt = full_ext[rpr_pkg::PAGE_W-1:0];
      end else begin
        idx_nxt  = idx_r + 1'b1;
        seen_nxt = seen_r + pop[RES_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
    idx_r    <= idx_nxt;
    seen_r   <= seen_nxt;
    k_r      <= k_nxt;
    victim_r <= victim_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.victim = victim_r;

endmodule

FILE: rtl/random_page_replacement_top.sv
// Random page replacement: one reference in, one result word out per reference.
// Busy is high while a reference is processed; a hit, a fill or an ignored page
// keeps busy high for one cycle and the result strobe follows in the next cycle.
// An eviction runs the victim scan, which reads the present map eight pages per
// cycle; busy stays high through the kick and scan states until the scan reports its victim.
// The result word is shown for exactly one cycle on out_valid and is never held;
// the receiver must take it then. Configuration writes are taken only while idle.
// Depends on rpr_pkg and rpr_scan.
module random_page_replacement_top #(
  parameter int PAGE_COUNT = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rpr_pkg::rpr_in_t   in_data,
  output logic               out_valid,
  output rpr_pkg::rpr_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [rpr_pkg::FRAME_W-1:0] cfg_data
);

  localparam int RES_W  = $clog2(PAGE_COUNT + 1);
  localparam int PG_W   = (PAGE_COUNT > 2) ? $clog2(PAGE_COUNT) : 1;
  localparam int EXT_W  = PG_W + rpr_pkg::PAGE_W + 1;
  localparam int CMP_W  = ((RES_W > rpr_pkg::FRAME_W) ? RES_W : rpr_pkg::FRAME_W) + 1;
  localparam int PROD_W = rpr_pkg::RAND_W + RES_W;
  localparam int CNT_X  = RES_W + rpr_pkg::COUNT_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_KICK   = 2'd2;
  localparam logic [1:0] S_SCAN   = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [rpr_pkg::PAGE_W-1:0]    page_r, page_nxt;
  logic [rpr_pkg::RAND_W-1:0]    rnd_r, rnd_nxt;
  logic                          last_r, last_nxt;
  logic [RES_W-1:0]              k_r, k_nxt;
  logic [PAGE_COUNT-1:0]         map_r, map_nxt;
  logic [RES_W-1:0]              res_r, res_nxt;
  logic [rpr_pkg::HITS_W-1:0]    hits_r, hits_nxt;
  logic [rpr_pkg::FRAME_W-1:0]   frame_r, frame_nxt;
  logic                          out_valid_r, out_valid_nxt;
  rpr_pkg::rpr_out_t             out_r, out_nxt;

  rpr_pkg::rpr_scan_rsp_t        scan_rsp;
  logic                          scan_start;

  logic [EXT_W-1:0]              page_ext;
  logic [EXT_W-1:0]              victim_ext;
  logic [PG_W-1:0]               page_idx;
  logic [PG_W-1:0]               victim_idx;
  logic                          page_ok;
  logic [CMP_W-1:0]              frames_eff;
  logic [PROD_W-1:0]             prod;
  logic [CNT_X-1:0]              res_ext;
  logic                          fin, f_hit, f_ev;
  logic [rpr_pkg::PAGE_W-1:0]    f_evp;

  // Page and victim indexes into the map
  assign page_ext   = EXT_W'(page_r);
  assign victim_ext = EXT_W'(scan_rsp.victim);
  assign page_idx   = page_ext[PG_W-1:0];
  assign victim_idx = victim_ext[PG_W-1:0];
  assign page_ok    = page_ext < EXT_W'(PAGE_COUNT);

  // Clamp the frame count to one..PAGE_COUNT
  always_comb begin
    frames_eff = CMP_W'(frame_r);
    if (frame_r == '0) begin
      frames_eff = CMP_W'(1);
    end else if (CMP_W'(frame_r) > CMP_W'(PAGE_COUNT)) begin
      frames_eff = CMP_W'(PAGE_COUNT);
    end
  end

  // Victim rank from the random draw
  assign prod = PROD_W'(rnd_r) * PROD_W'(res_r);

  assign scan_start = (state_r == S_KICK);

  rpr_scan #(
    .PAGE_COUNT (PAGE_COUNT),
    .RES_W      (RES_W)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .k     (k_r),
    .map   (map_r),
    .rsp   (scan_rsp)
  );

  // Sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    page_nxt      = page_r;
    rnd_nxt       = rnd_r;
    last_nxt      = last_r;
    k_nxt         = k_r;
    map_nxt       = map_r;
    res_nxt       = res_r;
    hits_nxt      = hits_r;
    frame_nxt     = frame_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    fin           = 1'b0;
    f_hit         = 1'b0;
    f_ev          = 1'b0;
    f_evp         = '0;
    res_ext       = '0;

    if (cfg_valid && cfg_ready) begin
      frame_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          page_nxt  = in_data.page;
          rnd_nxt   = in_data.random_value;
          last_nxt  = in_data.last_of_run;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!page_ok) begin
          fin = 1'b1;
        end else if (map_r[page_idx]) begin
          fin   = 1'b1;
          f_hit = 1'b1;
          if (hits_r != '1) begin
            hits_nxt = hits_r + 1'b1;
          end
        end else if (CMP_W'(res_r) < frames_eff) begin
          fin               = 1'b1;
          map_nxt[page_idx] = 1'b1;
          res_nxt           = res_r + 1'b1;
        end else begin
          k_nxt     = prod[PROD_W-1:rpr_pkg::RAND_W];
          state_nxt = S_KICK;
        end
      end
      S_KICK: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_rsp.done) begin
          fin                 = 1'b1;
          f_ev                = 1'b1;
          f_evp               = scan_rsp.victim;
          map_nxt[victim_idx] = 1'b0;
          map_nxt[page_idx]   = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Emit the result word, then drop the run state on its last reference
    if (fin) begin
      res_ext                = CNT_X'(res_nxt);
      state_nxt              = S_IDLE;
      out_valid_nxt          = 1'b1;
      out_nxt.hit            = f_hit;
      out_nxt.evicted_valid  = f_ev;
      out_nxt.evicted_page   = f_evp;
      out_nxt.hit_total      = hits_nxt;
      out_nxt.resident_count = res_ext[rpr_pkg::COUNT_W-1:0];
      out_nxt.run_end        = last_r;
      if (last_r) begin
        map_nxt  = '0;
        res_nxt  = '0;
        hits_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      map_r       <= '0;
      res_r       <= '0;
      hits_r      <= '0;
      frame_r     <= rpr_pkg::FRAME_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      map_r       <= map_nxt;
      res_r       <= res_nxt;
      hits_r      <= hits_nxt;
      frame_r     <= frame_nxt;
      out_valid_r <= out_valid_nxt;
    end
    page_r <= page_nxt;
    rnd_r  <= rnd_nxt;
    last_r <= last_nxt;
    k_r    <= k_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: verif/rpr_checker.sv
`timescale 1ns / 100ps
// Checker for the random page replacement block: watches the reference, result
// and frame count channels, predicts each result word and compares it.
// Depends on rpr_pkg.
module rpr_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  rpr_pkg::rpr_in_t            in_data,
  input  logic                        out_valid,
  input  rpr_pkg::rpr_out_t           out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [rpr_pkg::FRAME_W-1:0] cfg_data,
  output int                          fail_count,
  output int                          pending,
  output int                          checked_count,
  output int                          hit_count,
  output int                          evict_count
);

  localparam int PAGES  = 128;
  localparam int PAGE_W = rpr_pkg::PAGE_W;

  // Predicted page table and counters
  logic [PAGES-1:0]            present_pages;
  logic [rpr_pkg::COUNT_W-1:0] resident_pages;
  logic [rpr_pkg::HITS_W-1:0]  run_hits;
  logic [rpr_pkg::FRAME_W-1:0] frame_limit;

  rpr_pkg::rpr_out_t expected_results[$];

  initial begin
    fail_count    = 0;
    checked_count = 0;
    hit_count     = 0;
    evict_count   = 0;
    pending       = 0;
  end

  // Print one line per mismatch (bounded) and count it
  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (fail_count < 60)
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    fail_count++;
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got)
      report_mismatch(what, want, got);
  endtask

  // Apply one reference to the predicted state and return its result word
  function automatic rpr_pkg::rpr_out_t predict_reference(rpr_pkg::rpr_in_t w);
    rpr_pkg::rpr_out_t           r;
    logic [rpr_pkg::FRAME_W-1:0] frames;
    logic [23:0]                 scaled;
    logic [7:0]                  rank;
    logic [7:0]                  seen;
    logic [PAGE_W-1:0]           victim;
    logic                        found;
    r      = '0;
    frames = frame_limit;
    if (frames == 8'd0)
      frames = 8'd1;
    if (frames > 8'(PAGES))
      frames = 8'(PAGES);

    if (present_pages[w.page]) begin
      r.hit = 1'b1;
      if (run_hits != '1)
        run_hits = run_hits + 1'b1;
    end else if (resident_pages < frames) begin
      present_pages[w.page] = 1'b1;
      resident_pages        = resident_pages + 1'b1;
    end else begin
      // Victim is the rank-th present page counting up from page 0
      scaled = {8'd0, w.random_value} * {16'd0, resident_pages};
      rank   = scaled[23:16];
      seen   = '0;
      victim = '0;
      found  = 1'b0;
      for (int p = 0; p < PAGES; p++) begin
        if (present_pages[p] && !found) begin
          if (seen == rank) begin
            victim = PAGE_W'(p);
            found  = 1'b1;
          end
          seen++;
        end
      end
      present_pages[victim] = 1'b0;
      present_pages[w.page] = 1'b1;
      r.evicted_valid       = 1'b1;
      r.evicted_page        = victim;
    end

    r.hit_total      = run_hits;
    r.resident_count = resident_pages;
    r.run_end        = w.last_of_run;

    // Drop the whole run after its final reference
    if (w.last_of_run) begin
      present_pages  = '0;
      resident_pages = '0;
      run_hits       = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rpr_pkg::rpr_out_t want;
    if (!rst_n) begin
      present_pages  = '0;
      resident_pages = '0;
      run_hits       = '0;
      frame_limit    = rpr_pkg::FRAME_RESET;
      expected_results.delete();
      pending <= 0;
    end else begin
      // Compare the result word against the oldest prediction
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word", 32'd0, out_data.hit_total);
        end else begin
          want = expected_results.pop_front();
          check_field("hit", want.hit, out_data.hit);
          check_field("evicted_valid", want.evicted_valid, out_data.evicted_valid);
          check_field("evicted_page", want.evicted_page, out_data.evicted_page);
          check_field("hit_total", want.hit_total, out_data.hit_total);
          check_field("resident_count", want.resident_count, out_data.resident_count);
          check_field("run_end", want.run_end, out_data.run_end);
          checked_count++;
          if (want.hit)
            hit_count++;
          if (want.evicted_valid)
            evict_count++;
        end
      end
      // Track frame count writes
      if (cfg_valid && cfg_ready)
        frame_limit = cfg_data;
      // Predict every accepted reference word
      if (start && !busy)
        expected_results.push_back(predict_reference(in_data));
      pending <= expected_results.size();
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for the random page replacement block: drives references and
// frame count writes, and reports the verdict from rpr_checker.
// Depends on rpr_pkg, random_page_replacement_top and rpr_checker.
module tb;

  localparam int PAGE_W  = rpr_pkg::PAGE_W;
  localparam int RAND_W  = rpr_pkg::RAND_W;
  localparam int FRAME_W = rpr_pkg::FRAME_W;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  rpr_pkg::rpr_in_t   in_data;
  logic               out_valid;
  rpr_pkg::rpr_out_t  out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [FRAME_W-1:0] cfg_data;

  int fails;
  int pending;
  int checked;
  int hits;
  int evicts;
  int sent_count;
  int cfg_count;

  random_page_replacement_top #(.PAGE_COUNT(128)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rpr_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fails),
    .pending       (pending),
    .checked_count (checked),
    .hit_count     (hits),
    .evict_count   (evicts)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Bound the run
  initial begin
    #500000;
    $display("Run timed out with %0d result words outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Present one reference word, idling start on a share of the cycles
  task automatic issue_reference(logic [PAGE_W-1:0] pg, logic [RAND_W-1:0] rv,
                                 logic last, int idle_pct);
    rpr_pkg::rpr_in_t w;
    logic             idle;
    w.page         = pg;
    w.random_value = rv;
    w.last_of_run  = last;
    do begin
      idle    = (idle_pct > 0) && ($urandom_range(99) < idle_pct);
      start   <= !idle;
      in_data <= w;
      @(posedge clk);
    end while (idle || busy);
    sent_count++;
  endtask

  // Drop start and wait until every result word has come back
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write the frame count while the block is idle
  task automatic write_frame_count(logic [FRAME_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_count++;
  endtask

  initial begin
    logic [FRAME_W-1:0] frame_plan[8];
    int                 idle_pct;
    int                 run_left;
    int                 window_base;
    int                 window_size;
    logic [PAGE_W-1:0]  pg;
    logic [RAND_W-1:0]  rv;
    logic               last;

    frame_plan = '{8'd1, 8'd128, 8'd5, 8'd0, 8'd255, 8'd16, 8'd3, 8'd96};
    sent_count = 0;
    cfg_count  = 0;
    run_left   = 0;
    window_base = 0;
    window_size = 4;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fills and hits at reset frame count, end of run on a hit
    issue_reference(7'd0, 16'h0000, 1'b0, 0);
    issue_reference(7'd127, 16'hFFFF, 1'b0, 0);
    issue_reference(7'd0, 16'h0000, 1'b0, 0);
    issue_reference(7'd127, 16'h0000, 1'b1, 0);
    drain();

    // Two frames: evict lowest and highest ranked victims
    write_frame_count(8'd2);
    issue_reference(7'd5, 16'h0000, 1'b0, 0);
    issue_reference(7'd9, 16'h0000, 1'b0, 0);
    issue_reference(7'd5, 16'h0000, 1'b0, 0);
    issue_reference(7'd100, 16'h0000, 1'b0, 0);
    issue_reference(7'd7, 16'hFFFF, 1'b0, 0);
    issue_reference(7'd9, 16'h8000, 1'b0, 0);
    issue_reference(7'd1, 16'h8000, 1'b1, 0);
    drain();

    // Zero frames acts as one frame
    write_frame_count(8'd0);
    issue_reference(7'd3, 16'h1234, 1'b0, 0);
    issue_reference(7'd4, 16'hFFFF, 1'b0, 0);
    issue_reference(7'd4, 16'h0000, 1'b1, 0);
    drain();

    // Frame count beyond page count, then lowered under the resident count
    write_frame_count(8'd255);
    for (int i = 1; i <= 6; i++)
      issue_reference(PAGE_W'(i * 10), 16'h0000, 1'b0, 0);
    drain();
    write_frame_count(8'd3);
    issue_reference(7'd70, 16'hFFFF, 1'b0, 0);
    issue_reference(7'd80, 16'h0000, 1'b0, 0);
    issue_reference(7'd20, 16'h0000, 1'b0, 0);
    issue_reference(7'd90, 16'h8000, 1'b1, 0);
    drain();

    // Random runs over a drifting working set, one frame setting per phase
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 49;
        2:       idle_pct = 0;
        default: idle_pct = 23;
      endcase
      write_frame_count(frame_plan[ph]);
      for (int n = 0; n < 63; n++) begin
        if (run_left == 0) begin
          run_left    = $urandom_range(8, 60);
          window_base = $urandom_range(0, 127);
          window_size = $urandom_range(2, 12);
        end
        if ($urandom_range(99) < 75)
          pg = PAGE_W'(window_base + $urandom_range(0, window_size - 1));
        else
          pg = PAGE_W'($urandom_range(0, 127));
        case ($urandom_range(9))
          0:       rv = 16'h0000;
          1:       rv = 16'hFFFF;
          default: rv = RAND_W'($urandom_range(0, 65535));
        endcase
        last = (run_left == 1) || ($urandom_range(99) < 3);
        if (last)
          run_left = 0;
        else
          run_left--;
        issue_reference(pg, rv, last, idle_pct);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d references over %0d frame count settings with sender gaps",
             sent_count, cfg_count);
    $display("Checked %0d result words: %0d hits, %0d evictions", checked, hits, evicts);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches found", fails);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: random_page_replacement_top.f
rtl/rpr_pkg.sv
rtl/rpr_scan.sv
rtl/random_page_replacement_top.sv
verif/rpr_checker.sv
verif/tb.sv
